[src/morse_character_encoder_assert.svh]
// Assertion macros shared by the Morse encoder RTL.
`ifndef MORSE_CHARACTER_ENCODER_ASSERT_SVH
`define MORSE_CHARACTER_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Concurrent assertion on an explicit clock and active-low reset.
`define MCE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MCE_ASSERT(label, prop, msg) \
  `MCE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define MCE_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define MCE_ASSERT(label, prop, msg)

`endif

`endif

[src/mce_pkg.sv]
// Types, constants and the character code table of the Morse encoder.
package mce_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned MarkMax = 6;
  localparam int unsigned CntW    = 3;
  localparam int unsigned OnW     = 2;
  localparam int unsigned OffW    = 3;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 8;

  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] CaseBit  = 8'h20;

  typedef enum logic [1:0] {
    KIND_DIT  = 2'd0,
    KIND_DAH  = 2'd1,
    KIND_CGAP = 2'd2,
    KIND_WGAP = 2'd3
  } elem_kind_e;

  // Marks of one character: first mark in the top bit, 1 is a dah.
  typedef struct packed {
    logic [CntW-1:0]    len;
    logic [MarkMax-1:0] marks;
  } code_t;

  // Key-down units of an element.
  function automatic logic [OnW-1:0] key_on_of(elem_kind_e kind);
    logic [OnW-1:0] on;
    unique case (kind)
      KIND_DIT: on = 2'd1;
      KIND_DAH: on = 2'd3;
      default:  on = 2'd0;
    endcase
    return on;
  endfunction

  // Key-up units after an element.
  function automatic logic [OffW-1:0] key_off_of(elem_kind_e kind);
    logic [OffW-1:0] off;
    unique case (kind)
      KIND_CGAP: off = 3'd2;
      KIND_WGAP: off = 3'd6;
      default:   off = 3'd1;
    endcase
    return off;
  endfunction

  // Code table lookup on a lower-case character; unknown bytes give no marks.
  function automatic code_t code_of(logic [CharW-1:0] c);
    code_t code;
    unique case (c)
      8'h61: code = '{3'd2, 6'b010000}; // a
      8'h62: code = '{3'd4, 6'b100000}; // b
      8'h63: code = '{3'd4, 6'b101000}; // c
      8'h64: code = '{3'd3, 6'b100000}; // d
      8'h65: code = '{3'd1, 6'b000000}; // e
      8'h66: code = '{3'd4, 6'b001000}; // f
      8'h67: code = '{3'd3, 6'b110000}; // g
      8'h68: code = '{3'd4, 6'b000000}; // h
      8'h69: code = '{3'd2, 6'b000000}; // i
      8'h6A: code = '{3'd4, 6'b011100}; // j
      8'h6B: code = '{3'd3, 6'b101000}; // k
      8'h6C: code = '{3'd4, 6'b010000}; // l
      8'h6D: code = '{3'd2, 6'b110000}; // m
      8'h6E: code = '{3'd2, 6'b100000}; // n
      8'h6F: code = '{3'd3, 6'b111000}; // o
      8'h70: code = '{3'd4, 6'b011000}; // p
      8'h71: code = '{3'd4, 6'b110100}; // q
      8'h72: code = '{3'd3, 6'b010000}; // r
      8'h73: code = '{3'd3, 6'b000000}; // s
      8'h74: code = '{3'd1, 6'b100000}; // t
      8'h75: code = '{3'd3, 6'b001000}; // u
      8'h76: code = '{3'd4, 6'b000100}; // v
      8'h77: code = '{3'd3, 6'b011000}; // w
      8'h78: code = '{3'd4, 6'b100100}; // x
      8'h79: code = '{3'd4, 6'b101100}; // y
      8'h7A: code = '{3'd4, 6'b110000}; // z
      8'h30: code = '{3'd5, 6'b111110}; // 0
      8'h31: code = '{3'd5, 6'b011110}; // 1
      8'h32: code = '{3'd5, 6'b001110}; // 2
      8'h33: code = '{3'd5, 6'b000110}; // 3
      8'h34: code = '{3'd5, 6'b000010}; // 4
      8'h35: code = '{3'd5, 6'b000000}; // 5
      8'h36: code = '{3'd5, 6'b100000}; // 6
      8'h37: code = '{3'd5, 6'b110000}; // 7
      8'h38: code = '{3'd5, 6'b111000}; // 8
      8'h39: code = '{3'd5, 6'b111100}; // 9
      8'h2C: code = '{3'd6, 6'b110011}; // comma
      8'h2E: code = '{3'd6, 6'b010101}; // period
      8'h3F: code = '{3'd6, 6'b001100}; // question mark
      8'h21: code = '{3'd5, 6'b001100}; // exclamation mark
      8'h22: code = '{3'd6, 6'b010010}; // double quote
      8'h27: code = '{3'd6, 6'b011110}; // apostrophe
      8'h2D: code = '{3'd6, 6'b100001}; // hyphen
      default: code = '{3'd0, 6'b000000};
    endcase
    return code;
  endfunction

endpackage

[src/morse_character_encoder.sv]
// Morse character encoder: turns character bytes into a stream of keying elements.
//
// Each request on the slave side is one ASCII byte; the master side returns its
// run of keying elements (an optional character or word gap, then up to six dits
// and dahs), one element per beat, with tlast on the final element of the run.
// The run register sends one element per cycle while the output register can
// take it; a character yields at most seven elements, and the next byte is
// taken in the cycle the last element of the previous run moves to the output
// register. A byte that yields no elements (a space at word start, an unknown
// byte at word start) produces no beat. Each element passes through the run
// register and then the output register.
module morse_character_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] char_code
  input  logic [mce_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] element_kind, [3:2] key_on_units, [6:4] key_off_units, [7] zero
  output logic [mce_pkg::OutTdataW-1:0]    m_axis_tdata,
  // last_of_run
  output logic                             m_axis_tlast
);
  import mce_pkg::*;

  `include "morse_character_encoder_assert.svh"

  // Word-start flag and the pending run.
  logic               word_start_q, word_start_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               sep_q, sep_d;
  logic               sep_wgap_q, sep_wgap_d;
  logic [MarkMax-1:0] marks_q, marks_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  elem_kind_e         out_kind_q, out_kind_d;
  logic               out_last_q, out_last_d;

  logic               emit;
  logic               accept;
  elem_kind_e         emit_kind;
  logic [CharW-1:0]   char_fold;
  code_t              code;
  logic               new_sep;
  logic               new_wgap;

  // Element leaves the run register when the output register is free.
  assign emit   = (cnt_q != '0) && (!out_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && emit);

  // Fold upper case and look up the code.
  always_comb begin
    char_fold = s_axis_tdata;
    if ((s_axis_tdata >= ChUpperA) && (s_axis_tdata <= ChUpperZ)) begin
      char_fold = s_axis_tdata | CaseBit;
    end
    code     = code_of(char_fold);
    new_sep  = !word_start_q;
    new_wgap = (char_fold == ChSpace);
  end

  // Kind of the element at the head of the run.
  always_comb begin
    if (sep_q) begin
      emit_kind = sep_wgap_q ? KIND_WGAP : KIND_CGAP;
    end else begin
      emit_kind = marks_q[MarkMax-1] ? KIND_DAH : KIND_DIT;
    end
  end

  // Run register and word-start update.
  always_comb begin
    word_start_d = word_start_q;
    cnt_d        = cnt_q;
    sep_d        = sep_q;
    sep_wgap_d   = sep_wgap_q;
    marks_d      = marks_q;
    if (emit) begin
      cnt_d = cnt_q - CntW'(1);
      if (sep_q) begin
        sep_d = 1'b0;
      end else begin
        marks_d = {marks_q[MarkMax-2:0], 1'b0};
      end
    end
    if (accept) begin
      word_start_d = word_start_q ? 1'b0 : new_wgap;
      sep_d        = new_sep;
      sep_wgap_d   = new_wgap;
      marks_d      = code.marks;
      cnt_d        = code.len + CntW'(new_sep);
    end
  end

  // Output register update.
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_last_d  = (cnt_q == CntW'(1));
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_start_q <= 1'b1;
      cnt_q        <= '0;
      sep_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      word_start_q <= word_start_d;
      cnt_q        <= cnt_d;
      sep_q        <= sep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sep_wgap_q <= sep_wgap_d;
    marks_q    <= marks_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  // Output beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, key_off_of(out_kind_q), key_on_of(out_kind_q), out_kind_q};

  // A word gap always closes its run.
  `MCE_ASSERT(a_wgap_last,
              (m_axis_tvalid && (out_kind_q == KIND_WGAP)) |-> m_axis_tlast,
              "word gap not last of run")
  // An unfinished run at the output still has elements waiting behind it.
  `MCE_ASSERT(a_run_continues,
              (m_axis_tvalid && !m_axis_tlast) |-> (cnt_q != '0),
              "run lost elements")
  // A pending separator is always counted in the run.
  `MCE_ASSERT(a_sep_counted,
              sep_q |-> (cnt_q != '0),
              "separator pending with empty run")

endmodule

[bench/tb_morse_character_encoder.sv]
// Self-checking testbench for the Morse character encoder stream block.
`timescale 1ns / 1ps

module tb_morse_character_encoder;
  import mce_pkg::*;

  localparam int unsigned RandomChars   = 290;
  localparam int unsigned QuietTail     = 40;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 16;

  // One keying element as it leaves the block.
  typedef struct packed {
    elem_kind_e      kind;
    logic [OnW-1:0]  on_units;
    logic [OffW-1:0] off_units;
    logic            last;
  } keying_t;

  // Directed row: a character and, where typed, its run written as symbols
  // ('.' dit, '-' dah, 'c' character gap, 'w' word gap).
  typedef struct {
    logic [CharW-1:0] ch;
    bit               typed;
    string            run;
  } char_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Predictor state and the elements still owed by the block.
  logic        word_start = 1'b1;
  keying_t     pending_elems[$];
  int unsigned error_count = 0;
  int unsigned stuck_cycles = 0;

  // Side information for the request on offer, and pacing controls.
  bit    offer_typed = 1'b0;
  string offer_run = "";
  bit    quiet_phase = 1'b0;
  bit    hold_request = 1'b0;

  // The directed table: word-start handling, case folding, unknown bytes and
  // the longest run first, then table entries left to the predictor.
  char_row_t char_rows [25] = '{
    '{" ",   1'b1, ""},
    '{"A",   1'b1, "c.-"},
    '{"Z",   1'b1, "c--.."},
    '{" ",   1'b1, "w"},
    '{"s",   1'b1, "..."},
    '{8'h00, 1'b1, "c"},
    '{8'hFF, 1'b1, "c"},
    '{8'hC1, 1'b1, "c"},
    '{"@",   1'b1, "c"},
    '{"[",   1'b1, "c"},
    '{" ",   1'b1, "w"},
    '{8'hFF, 1'b1, ""},
    '{" ",   1'b1, "w"},
    '{" ",   1'b1, ""},
    '{",",   1'b1, "c--..--"},
    '{"0",   1'b0, ""},
    '{"9",   1'b0, ""},
    '{".",   1'b0, ""},
    '{"?",   1'b0, ""},
    '{"!",   1'b0, ""},
    '{8'h22, 1'b0, ""},
    '{8'h27, 1'b0, ""},
    '{"-",   1'b0, ""},
    '{"a",   1'b0, ""},
    '{"z",   1'b0, ""}
  };

  morse_character_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Dits and dahs of a lower-case character; unknown bytes have none.
  function automatic string marks_of(logic [CharW-1:0] c);
    case (c)
      "a": return ".-";     "b": return "-...";   "c": return "-.-.";
      "d": return "-..";    "e": return ".";      "f": return "..-.";
      "g": return "--.";    "h": return "....";   "i": return "..";
      "j": return ".---";   "k": return "-.-";    "l": return ".-..";
      "m": return "--";     "n": return "-.";     "o": return "---";
      "p": return ".--.";   "q": return "--.-";   "r": return ".-.";
      "s": return "...";    "t": return "-";      "u": return "..-";
      "v": return "...-";   "w": return ".--";    "x": return "-..-";
      "y": return "-.--";   "z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ",": return "--..--"; ".": return ".-.-.-"; "?": return "..--..";
      "!": return "..--.";  8'h22: return ".-..-."; 8'h27: return ".----.";
      "-": return "-....-";
      default: return "";
    endcase
  endfunction

  // Run of symbols for one character; updates the word-start state.
  function automatic string encode_char(logic [CharW-1:0] raw);
    logic [CharW-1:0] c;
    string            sep;
    c = raw;
    sep = "";
    if (c >= ChUpperA && c <= ChUpperZ) begin
      c = c | CaseBit;
    end
    if (word_start) begin
      word_start = 1'b0;
    end else if (c != ChSpace) begin
      sep = "c";
    end else begin
      word_start = 1'b1;
      sep = "w";
    end
    return {sep, marks_of(c)};
  endfunction

  // Turn a run of symbols into the elements the block owes.
  function automatic void queue_elements(string run);
    keying_t elem;
    for (int k = 0; k < run.len(); k++) begin
      case (run[k])
        "-":     elem = '{KIND_DAH, 2'd3, 3'd1, 1'b0};
        "c":     elem = '{KIND_CGAP, 2'd0, 3'd2, 1'b0};
        "w":     elem = '{KIND_WGAP, 2'd0, 3'd6, 1'b0};
        default: elem = '{KIND_DIT, 2'd1, 3'd1, 1'b0};
      endcase
      elem.last = (k == run.len() - 1);
      pending_elems.push_back(elem);
    end
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Mostly text with random case, some spaces, and a share of arbitrary bytes.
  function automatic logic [CharW-1:0] pick_char();
    string       punct;
    int unsigned roll;
    punct = ",.?!\"'-";
    roll = $urandom_range(0, 99);
    if (roll < 40) return CharW'(8'h61 + $urandom_range(0, 25));
    if (roll < 55) return CharW'(8'h41 + $urandom_range(0, 25));
    if (roll < 65) return CharW'(8'h30 + $urandom_range(0, 9));
    if (roll < 75) return punct[$urandom_range(0, 6)];
    if (roll < 88) return ChSpace;
    return CharW'($urandom_range(0, 255));
  endfunction

  // Offer one request, after an optional idle burst, until it is taken.
  task automatic send_char(logic [CharW-1:0] ch, bit typed, string run);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    offer_typed = typed;
    offer_run = run;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Predict on each accepted request, check each accepted element, and
  // watch for a stuck stream.
  always @(posedge clk_i) begin : monitor
    bit      moved;
    string   run;
    keying_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        run = encode_char(s_axis_tdata);
        queue_elements(offer_typed ? offer_run : run);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (pending_elems.size() == 0) begin
          flag_error($sformatf("unexpected element, tdata %h", m_axis_tdata));
        end else begin
          want = pending_elems.pop_front();
          if (m_axis_tdata[1:0] != want.kind)
            flag_error($sformatf("kind %0d, expected %s", m_axis_tdata[1:0],
                                 want.kind.name()));
          if (m_axis_tdata[3:2] != want.on_units)
            flag_error($sformatf("key-on %0d, expected %0d", m_axis_tdata[3:2],
                                 want.on_units));
          if (m_axis_tdata[6:4] != want.off_units)
            flag_error($sformatf("key-off %0d, expected %0d", m_axis_tdata[6:4],
                                 want.off_units));
          if (m_axis_tlast != want.last)
            flag_error($sformatf("tlast %0b, expected %0b", m_axis_tlast, want.last));
        end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin : element_sink
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // Sender: reset, directed table, then random text.
  initial begin : char_source
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (char_rows[i]) begin
      send_char(char_rows[i].ch, char_rows[i].typed, char_rows[i].run);
    end

    for (int i = 0; i < RandomChars; i++) begin
      quiet_phase = (i >= RandomChars - QuietTail);
      // Long receiver hold-off while requests keep coming.
      if (i == 100) begin
        hold_request = 1'b1;
      end
      // Let the block drain completely before going on.
      if (i == 200) begin
        s_axis_tvalid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      send_char(pick_char(), 1'b0, "");
    end
    s_axis_tvalid <= 1'b0;

    // Wait for the last elements, then a short drain.
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_elems.size() != 0) begin
      flag_error("elements still owed at the end");
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
